/* sv/rrsp_pkg.sv */
// Shared types, constants and codes of the RESP request stream parser.
package rrsp_pkg;

  localparam int unsigned LenBits  = 31;
  localparam int unsigned SizeBits = LenBits + 1;
  localparam int unsigned AccBits  = LenBits + 5;
  localparam int unsigned IdxBits  = 31;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    PhWaitArray,
    PhWaitBulk,
    PhSizeText,
    PhSizeLf,
    PhData,
    PhDataCr,
    PhDataLf
  } phase_e;

  typedef enum logic [1:0] {
    EvPayload,
    EvArgEnd,
    EvNull,
    EvError
  } event_e;

  typedef enum logic [2:0] {
    ErrNone,
    ErrNoStar,
    ErrNoDollar,
    ErrBadSize,
    ErrCount,
    ErrLength,
    ErrCrLf
  } cause_e;

  typedef struct packed {
    logic               valid;
    event_e             kind;
    logic [7:0]         payload;
    logic [IdxBits-1:0] arg_index;
    logic               done;
    cause_e             cause;
  } result_t;

endpackage

/* sv/rrsp_in_reg.sv */
// Input register stage that holds one received byte until the parser takes it.
module rrsp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       take_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);
  import rrsp_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;

  // The slot frees up in the same cycle that the parser consumes it.
  assign in_ready_o   = !valid_q || take_i;
  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

/* sv/rrsp_core.sv */
// Parser state machine with size accumulation and argument counters.
module rrsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output rrsp_pkg::result_t res_o
);
  import rrsp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SizeBits-1:0]  size_value_q, size_value_d;
  logic                 size_neg_q, size_neg_d;
  logic                 size_digit_q, size_digit_d;
  logic                 size_bad_q, size_bad_d;
  logic [LenBits-1:0]   args_exp_q, args_exp_d;
  logic [LenBits-1:0]   args_rcv_q, args_rcv_d;
  logic [LenBits-1:0]   pay_left_q, pay_left_d;
  logic                 is_array_q, is_array_d;

  logic                 is_digit;
  logic [AccBits-1:0]   acc_next;
  logic [AccBits-1:0]   acc_lim;
  logic [LenBits-1:0]   args_inc;
  logic                 last_arg;
  logic                 mag_zero;
  logic                 mag_one;
  logic [LenBits-1:0]   pay_dec;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign acc_next = {{(AccBits-SizeBits-3){1'b0}}, size_value_q, 3'b000}
                  + {{(AccBits-SizeBits-1){1'b0}}, size_value_q, 1'b0}
                  + {{(AccBits-4){1'b0}}, byte_i[3:0]};
  // A negative size may reach one step further than a positive one.
  assign acc_lim  = size_neg_q ? (AccBits'(1) << LenBits) : ((AccBits'(1) << LenBits) - 1'b1);
  assign args_inc = args_rcv_q + 1'b1;
  assign last_arg = (args_inc == args_exp_q);
  assign mag_zero = (size_value_q == '0);
  assign mag_one  = (size_value_q == SizeBits'(1));
  assign pay_dec  = pay_left_q - 1'b1;

  // Result of the current byte.
  always_comb begin
    res_o           = '0;
    res_o.kind      = EvPayload;
    res_o.cause     = ErrNone;
    res_o.arg_index = IdxBits'(args_rcv_q);
    unique case (phase_q)
      PhWaitArray: begin
        if (byte_i != ChStar) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrNoStar;
        end
      end
      PhWaitBulk: begin
        if (byte_i != ChDollar) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrNoDollar;
        end
      end
      PhSizeText: begin
        res_o.valid = 1'b0;
      end
      PhSizeLf: begin
        if (byte_i != ChLf) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrCrLf;
        end else if (size_bad_q || !size_digit_q) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrBadSize;
        end else if (is_array_q) begin
          if (size_neg_q || mag_zero) begin
            res_o.valid = 1'b1;
            res_o.kind  = EvError;
            res_o.cause = ErrCount;
          end
        end else if (size_neg_q && mag_one) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvNull;
          res_o.done  = last_arg;
        end else if (size_neg_q && !mag_zero) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrLength;
        end
      end
      PhData: begin
        res_o.valid   = 1'b1;
        res_o.kind    = EvPayload;
        res_o.payload = byte_i;
      end
      PhDataCr: begin
        if (byte_i != ChCr) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvError;
          res_o.cause = ErrCrLf;
        end
      end
      PhDataLf: begin
        res_o.valid = 1'b1;
        if (byte_i != ChLf) begin
          res_o.kind  = EvError;
          res_o.cause = ErrCrLf;
        end else begin
          res_o.kind = EvArgEnd;
          res_o.done = last_arg;
        end
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
    res_o.valid = res_o.valid && step_i;
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    size_value_d = size_value_q;
    size_neg_d   = size_neg_q;
    size_digit_d = size_digit_q;
    size_bad_d   = size_bad_q;
    args_exp_d   = args_exp_q;
    args_rcv_d   = args_rcv_q;
    pay_left_d   = pay_left_q;
    is_array_d   = is_array_q;
    if (res_o.valid && (res_o.kind == EvError)) begin
      // Any framing fault returns every piece of state to its reset value.
      phase_d      = PhWaitArray;
      size_value_d = '0;
      size_neg_d   = 1'b0;
      size_digit_d = 1'b0;
      size_bad_d   = 1'b0;
      args_exp_d   = '0;
      args_rcv_d   = '0;
      pay_left_d   = '0;
      is_array_d   = 1'b1;
    end else begin
      unique case (phase_q)
        PhWaitArray, PhWaitBulk: begin
          size_value_d = '0;
          size_neg_d   = 1'b0;
          size_digit_d = 1'b0;
          size_bad_d   = 1'b0;
          is_array_d   = (phase_q == PhWaitArray);
          phase_d      = PhSizeText;
        end
        PhSizeText: begin
          if (byte_i == ChCr) begin
            phase_d = PhSizeLf;
          end else if (is_digit) begin
            size_digit_d = 1'b1;
            if (acc_next > acc_lim) begin
              size_bad_d = 1'b1;
            end else begin
              size_value_d = acc_next[SizeBits-1:0];
            end
          end else if (byte_i == ChMinus && !size_neg_q && !size_digit_q) begin
            size_neg_d = 1'b1;
          end else begin
            size_bad_d = 1'b1;
          end
        end
        PhSizeLf: begin
          size_value_d = '0;
          size_neg_d   = 1'b0;
          size_digit_d = 1'b0;
          size_bad_d   = 1'b0;
          if (is_array_q) begin
            args_exp_d = size_value_q[LenBits-1:0];
            args_rcv_d = '0;
            phase_d    = PhWaitBulk;
          end else if (size_neg_q && mag_one) begin
            // A null argument is finished as soon as its size line ends.
            if (last_arg) begin
              phase_d    = PhWaitArray;
              args_exp_d = '0;
              args_rcv_d = '0;
              is_array_d = 1'b1;
            end else begin
              args_rcv_d = args_inc;
              phase_d    = PhWaitBulk;
            end
          end else begin
            pay_left_d = size_value_q[LenBits-1:0];
            phase_d    = mag_zero ? PhDataCr : PhData;
          end
        end
        PhData: begin
          pay_left_d = pay_dec;
          if (pay_dec == '0) begin
            phase_d = PhDataCr;
          end
        end
        PhDataCr: begin
          phase_d = PhDataLf;
        end
        PhDataLf: begin
          if (last_arg) begin
            phase_d    = PhWaitArray;
            args_exp_d = '0;
            args_rcv_d = '0;
            is_array_d = 1'b1;
          end else begin
            args_rcv_d = args_inc;
            phase_d    = PhWaitBulk;
          end
        end
        default: begin
          phase_d      = PhWaitArray;
          size_value_d = '0;
          size_neg_d   = 1'b0;
          size_digit_d = 1'b0;
          size_bad_d   = 1'b0;
          args_exp_d   = '0;
          args_rcv_d   = '0;
          pay_left_d   = '0;
          is_array_d   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhWaitArray;
      size_value_q <= '0;
      size_neg_q   <= 1'b0;
      size_digit_q <= 1'b0;
      size_bad_q   <= 1'b0;
      args_exp_q   <= '0;
      args_rcv_q   <= '0;
      pay_left_q   <= '0;
      is_array_q   <= 1'b1;
    end else if (step_i) begin
      phase_q      <= phase_d;
      size_value_q <= size_value_d;
      size_neg_q   <= size_neg_d;
      size_digit_q <= size_digit_d;
      size_bad_q   <= size_bad_d;
      args_exp_q   <= args_exp_d;
      args_rcv_q   <= args_rcv_d;
      pay_left_q   <= pay_left_d;
      is_array_q   <= is_array_d;
    end
  end

endmodule

/* sv/rrsp_out_reg.sv */
// Result register that holds one event until the downstream side takes it.
module rrsp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrsp_pkg::result_t res_i,
  output logic              load_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrsp_pkg::result_t out_o
);
  import rrsp_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign load_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_o        = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && res_i.valid) begin
      data_q <= res_i;
    end
  end

endmodule

/* sv/resp_request_stream_parser_unit.sv */
// Top level of the RESP request stream parser: input register, parser, result register.
//
//   Channel   Dir  Width  Contents
//   s_axis    in   8      tdata: in_byte
//   m_axis    out  48+1   tdata: event_kind, payload_byte, arg_index, error_cause;
//                         tlast: request_done
//
// A byte is held in the input register until its result is loaded into the result register,
// and one byte is taken every cycle while m_axis does not stall.
// The parser state and counters update in a single step per byte.
// Reset (rst_ni low) empties both registers and returns the parser to waiting for '*'.
// A stall on m_axis holds the result; s_axis then fills its one-byte register and stops.
module resp_request_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] event_kind, [9:2] payload_byte, [40:10] arg_index, [43:41] error_cause,
  // [47:44] zero
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // request_done
);
  import rrsp_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       load_ready;
  logic       step;
  result_t    res;
  result_t    out_res;

  assign step = held_valid && load_ready;

  rrsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .take_i       (step),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  rrsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (held_byte),
    .res_o  (res)
  );

  rrsp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .load_ready_o (load_ready),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (out_res)
  );

  assign m_axis_tdata_o = {4'b0000, out_res.cause, out_res.arg_index, out_res.payload,
                           out_res.kind};
  assign m_axis_tlast_o = out_res.done;

  // The input side only stalls while a byte is held and cannot move on.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (held_valid && !load_ready))
    else $error("input stalled with nothing blocking it");

  // Only an argument end or a null argument may close a request.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (out_res.kind == EvArgEnd || out_res.kind == EvNull))
    else $error("request completion on a wrong event kind");

  // A cause is present exactly for error events.
  a_cause_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((out_res.kind == EvError) == (out_res.cause != ErrNone)))
    else $error("error cause does not match event kind");

  // A payload byte only travels with a payload event.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_res.kind != EvPayload) |-> (out_res.payload == 8'h00))
    else $error("nonzero payload byte on a non-payload event");

endmodule
